FILE: rtl/aim_velocity_toward_target_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AIM_VELOCITY_TOWARD_TARGET_TOP_MACROS_SVH
`define AIM_VELOCITY_TOWARD_TARGET_TOP_MACROS_SVH
`ifndef SYNTH
`define AVT_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define AVT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AVT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AVT_ASSERT(lbl, clk, rstn, expr)
`define AVT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AVT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/avt_pkg.sv
// ----------------------------------------------------------------------------
// Aim velocity package
// Shared constants for the aim velocity block.
// ----------------------------------------------------------------------------
package avt_pkg;

  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned FIFO_DEPTH     = 4;

endpackage

FILE: rtl/avt_front.sv
// ----------------------------------------------------------------------------
// Aim velocity front end
// Forms the difference vector, its squared length and a pipelined integer
// square root, one root bit per stage.
// ----------------------------------------------------------------------------
module avt_front #(
  parameter int unsigned COORD_BITS = avt_pkg::COORD_BITS_DEF,
  localparam int unsigned DW  = COORD_BITS + 1,
  localparam int unsigned SPW = COORD_BITS - 1,
  localparam int unsigned OW  = 3 * DW + SPW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic [COORD_BITS-1:0] target_x_i,
  input  logic [COORD_BITS-1:0] target_y_i,
  input  logic [SPW-1:0]        speed_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OW-1:0]         out_data_o
);

  localparam int unsigned SW  = 2 * DW;
  localparam int unsigned RB  = DW;
  localparam int unsigned RMW = RB + 2;
  localparam int unsigned CW  = 2 * DW + SPW;
  localparam int unsigned NST = RB + 3;

  logic           v_q   [NST];
  logic [CW-1:0]  car_q [NST];
  logic [SW-1:0]  sqx_q, sqy_q;
  logic [SW-1:0]  s_q    [RB+1];
  logic [RMW-1:0] rem_q  [RB+1];
  logic [RB-1:0]  root_q [RB+1];
  logic [RMW-1:0] rem_d  [RB];
  logic [RB-1:0]  root_d [RB];

  logic          adv;
  logic [DW-1:0] dx_d, dy_d, dx0, dy0, mx, my;

  assign adv        = !v_q[NST-1] || out_ready_i;
  assign in_ready_o = adv;

  assign dx_d = {target_x_i[COORD_BITS-1], target_x_i} - {pos_x_i[COORD_BITS-1], pos_x_i};
  assign dy_d = {target_y_i[COORD_BITS-1], target_y_i} - {pos_y_i[COORD_BITS-1], pos_y_i};
  assign dx0  = car_q[0][DW-1:0];
  assign dy0  = car_q[0][2*DW-1:DW];
  assign mx   = dx0[DW-1] ? (~dx0 + 1'b1) : dx0;
  assign my   = dy0[DW-1] ? (~dy0 + 1'b1) : dy0;

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    logic [RMW+1:0] rem2, trial, diff;
    logic           ge;
    assign rem2      = {rem_q[j], s_q[j][SW-1 -: 2]};
    assign trial     = {2'b00, root_q[j], 2'b01};
    assign ge        = rem2 >= trial;
    assign diff      = rem2 - trial;
    assign rem_d[j]  = ge ? diff[RMW-1:0] : rem2[RMW-1:0];
    assign root_d[j] = {root_q[j][RB-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      car_q[0] <= {speed_i, dy_d, dx_d};
      for (int i = 1; i < NST; i++) car_q[i] <= car_q[i-1];
      sqx_q     <= mx * mx;
      sqy_q     <= my * my;
      s_q[0]    <= sqx_q + sqy_q;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      for (int j = 0; j < RB; j++) begin
        s_q[j+1]    <= {s_q[j][SW-3:0], 2'b00};
        rem_q[j+1]  <= rem_d[j];
        root_q[j+1] <= root_d[j];
      end
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign out_data_o  = {car_q[NST-1], root_q[RB]};

endmodule

FILE: rtl/avt_fifo.sv
// ----------------------------------------------------------------------------
// Aim velocity queue
// Small register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "aim_velocity_toward_target_top_macros.svh"

module avt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = avt_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign in_ready_o  = cnt_q != (AW+1)'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  `AVT_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_q <= (AW+1)'(DEPTH))
  `AVT_ASSERT_IMP(a_ptr_gap, clk_i, rst_ni, cnt_q == '0, wr_q == rd_q)
  `AVT_ASSERT_NXT(a_push_cnt, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + 1'b1)

endmodule

FILE: rtl/avt_back.sv
// ----------------------------------------------------------------------------
// Aim velocity back end
// Applies the short-range fallback and scales both components by speed over
// length through two pipelined restoring dividers.
// ----------------------------------------------------------------------------
module avt_back #(
  parameter int unsigned COORD_BITS = avt_pkg::COORD_BITS_DEF,
  localparam int unsigned DW  = COORD_BITS + 1,
  localparam int unsigned SPW = COORD_BITS - 1,
  localparam int unsigned IW  = 3 * DW + SPW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [COORD_BITS-1:0] min_dist_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [IW-1:0]         in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] vel_x_o,
  output logic [COORD_BITS-1:0] vel_y_o,
  output logic                  too_close_o
);

  localparam int unsigned QB = SPW;
  localparam int unsigned NW = DW + SPW;

  logic [DW-1:0]  len_i, d_i [2];
  logic [SPW-1:0] spd_i;
  logic           fb_d, adv;

  logic           v_q    [QB+1];
  logic           fb_q   [QB+1];
  logic [DW-1:0]  len_q  [QB+1];
  logic [SPW-1:0] spd_q  [QB+1];
  logic           neg_q  [2][QB+1];
  logic [DW-1:0]  rem_q  [2][QB+1];
  logic [QB-1:0]  nlo_q  [2][QB+1];
  logic [QB-1:0]  quo_q  [2][QB+1];
  logic [DW-1:0]  rem_d  [2][QB];
  logic [QB-1:0]  quo_d  [2][QB];
  logic [NW-1:0]  prod   [2];
  logic [COORD_BITS-1:0] vel_d [2];

  logic                  ov_q, tc_q;
  logic [COORD_BITS-1:0] vx_q, vy_q;

  assign len_i = in_data_i[DW-1:0];
  assign d_i[0] = in_data_i[2*DW-1:DW];
  assign d_i[1] = in_data_i[3*DW-1:2*DW];
  assign spd_i = in_data_i[IW-1:3*DW];
  assign fb_d  = (len_i == '0) || (len_i < {1'b0, min_dist_i});

  assign adv        = !ov_q || out_ready_i;
  assign in_ready_o = adv;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [DW-1:0] mag;
    logic [QB:0]   qx;
    assign mag  = d_i[l][DW-1] ? (~d_i[l] + 1'b1) : d_i[l];
    assign prod[l] = mag * spd_i;
    for (genvar j = 0; j < QB; j++) begin : g_div
      logic [DW:0] rem2, dv, diff;
      logic        ge;
      assign rem2 = {rem_q[l][j], nlo_q[l][j][QB-1]};
      assign dv   = {1'b0, len_q[j]};
      assign ge   = rem2 >= dv;
      assign diff = rem2 - dv;
      assign rem_d[l][j] = ge ? diff[DW-1:0] : rem2[DW-1:0];
      assign quo_d[l][j] = {quo_q[l][j][QB-2:0], ge};
    end
    assign qx = {1'b0, quo_q[l][QB]};
    always_comb begin
      if (fb_q[QB]) begin
        vel_d[l] = (l == 0) ? {1'b0, spd_q[QB]} : '0;
      end else begin
        vel_d[l] = neg_q[l][QB] ? (~qx + 1'b1) : qx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QB; i++) v_q[i] <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_valid_i;
      for (int i = 1; i <= QB; i++) v_q[i] <= v_q[i-1];
      ov_q <= v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fb_q[0]  <= fb_d;
      len_q[0] <= len_i;
      spd_q[0] <= spd_i;
      for (int i = 1; i <= QB; i++) begin
        fb_q[i]  <= fb_q[i-1];
        len_q[i] <= len_q[i-1];
        spd_q[i] <= spd_q[i-1];
      end
      for (int l = 0; l < 2; l++) begin
        neg_q[l][0] <= d_i[l][DW-1];
        rem_q[l][0] <= prod[l][NW-1:QB];
        nlo_q[l][0] <= prod[l][QB-1:0];
        quo_q[l][0] <= '0;
        for (int j = 0; j < QB; j++) begin
          neg_q[l][j+1] <= neg_q[l][j];
          rem_q[l][j+1] <= rem_d[l][j];
          nlo_q[l][j+1] <= {nlo_q[l][j][QB-2:0], 1'b0};
          quo_q[l][j+1] <= quo_d[l][j];
        end
      end
      vx_q <= vel_d[0];
      vy_q <= vel_d[1];
      tc_q <= fb_q[QB];
    end
  end

  assign out_valid_o = ov_q;
  assign vel_x_o     = vx_q;
  assign vel_y_o     = vy_q;
  assign too_close_o = tc_q;

endmodule

FILE: rtl/aim_velocity_toward_target_top.sv
// ----------------------------------------------------------------------------
// Aim velocity toward target
// Velocity of a given speed pointing from a position to a target (along x if too close).
//
// Channel  Dir  Beat contents
// s_axis   in   pos_x, pos_y, target_x, target_y, speed_mag
// m_axis   out  vel_x, vel_y in tdata; too_close in tuser
// cfg      in   min_distance write
//
// One beat is accepted per cycle unless a full queue holds the front end. Each
// result passes through the front end's one-bit-per-stage root, the queue and
// the back end's one-bit-per-stage dividers, then the back end's output register.
// Reset clears all valid flags and min_distance. A stalled output holds the
// back end; the queue then lets the front end keep accepting until it fills.
// ----------------------------------------------------------------------------
module aim_velocity_toward_target_top #(
  parameter int unsigned COORD_BITS = avt_pkg::COORD_BITS_DEF,
  localparam int unsigned IDW = ((5 * COORD_BITS - 1) + 7) / 8 * 8,
  localparam int unsigned ODW = ((2 * COORD_BITS) + 7) / 8 * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [COORD_BITS-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_x, pos_y, target_x, target_y, speed_mag, zero fill
  input  logic [IDW-1:0]        s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // vel_x, vel_y, zero fill
  output logic [ODW-1:0]        m_axis_tdata,
  // too_close
  output logic                  m_axis_tuser
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned DW  = C + 1;
  localparam int unsigned QW  = 3 * DW + C - 1;

  logic [C-1:0]  min_dist_q;
  logic          f_valid, f_ready, q_valid, q_ready;
  logic [QW-1:0] f_data, q_data;
  logic [C-1:0]  vel_x, vel_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= '0;
    end else if (cfg_we_i) begin
      min_dist_q <= cfg_wdata_i;
    end
  end

  avt_front #(.COORD_BITS(C)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pos_x_i     (s_axis_tdata[C-1:0]),
    .pos_y_i     (s_axis_tdata[2*C-1:C]),
    .target_x_i  (s_axis_tdata[3*C-1:2*C]),
    .target_y_i  (s_axis_tdata[4*C-1:3*C]),
    .speed_i     (s_axis_tdata[5*C-2:4*C]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (f_data)
  );

  avt_fifo #(.WIDTH(QW), .DEPTH(avt_pkg::FIFO_DEPTH)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_data),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  avt_back #(.COORD_BITS(C)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_dist_i  (min_dist_q),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_data_i   (q_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .vel_x_o     (vel_x),
    .vel_y_o     (vel_y),
    .too_close_o (m_axis_tuser)
  );

  assign m_axis_tdata = ODW'({vel_y, vel_x});

endmodule
